@@ sv/slxfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfr_pkg
// Shared constants and types for the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package slxfr_pkg;

	typedef logic [1:0] status_t;

	localparam logic [7:0] START_ONE = 8'h06;
	localparam logic [7:0] START_TWO = 8'h85;

	localparam status_t ST_DATA       = 2'd0;
	localparam status_t ST_BAD_START  = 2'd1;
	localparam status_t ST_BAD_LENGTH = 2'd2;
	localparam status_t ST_BAD_CHECK  = 2'd3;

	localparam logic [6:0] EXP_LEN_RESET = 7'd8;

endpackage

@@ sv/slxfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slxfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/sync_length_xor_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// Hunts for 06 85 <len> <payload> <check> frames, checks the length against
// expected_length and the XOR check (seeded with the length), then releases
// the buffered payload as a run of transfers ended by tlast.
// ----------------------------------------------------------------------------
// A received byte is accepted only while the output register is empty, so
// after a byte that yields an error result the next byte waits until that
// result is taken. After a good check byte the payload is read back through
// the single read port of the payload RAM: S_RD sets the address, S_LOAD loads
// the output register, waiting out master stalls; no byte is taken meanwhile.
// Errors carry tdata zero, tlast high and the error code on tuser.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_receiver
	import slxfr_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,      // expected_length
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [1:0] status
	output logic       m_axis_tlast
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

	localparam logic [2:0] S_HUNT    = 3'd0;
	localparam logic [2:0] S_SECOND  = 3'd1;
	localparam logic [2:0] S_LENGTH  = 3'd2;
	localparam logic [2:0] S_PAYLOAD = 3'd3;
	localparam logic [2:0] S_CHECK   = 3'd4;
	localparam logic [2:0] S_RD      = 3'd5;
	localparam logic [2:0] S_LOAD    = 3'd6;

	logic [2:0]    state_q;
	logic [6:0]    exp_len_q;
	logic [7:0]    check_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          m_valid_q;
	logic [7:0]    m_data_q;
	status_t       m_user_q;
	logic          m_last_q;

	logic          rx_state;
	logic          in_xfer;
	logic          out_free;
	logic [7:0]    cmp_b;
	logic          cmp_eq;
	logic [CW-1:0] count_nxt;
	logic [CW-1:0] rd_idx_nxt;
	logic          len_bad_cfg;
	logic          wr_en;
	logic          rd_en;
	logic [7:0]    ram_q;

	assign rx_state = (state_q == S_HUNT) || (state_q == S_SECOND) ||
		(state_q == S_LENGTH) || (state_q == S_PAYLOAD) || (state_q == S_CHECK);
	assign s_axis_tready = rx_state && !m_valid_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// shared byte comparator
	always_comb begin
		case (state_q)
			S_HUNT:   cmp_b = START_ONE;
			S_SECOND: cmp_b = START_TWO;
			S_LENGTH: cmp_b = {1'b0, exp_len_q};
			default:  cmp_b = check_q;
		endcase
	end
	assign cmp_eq = (s_axis_tdata == cmp_b);

	assign len_bad_cfg = (exp_len_q == 7'd0) || ({1'b0, exp_len_q} > MAX_B);
	assign count_nxt   = count_q + CW'(1);
	assign rd_idx_nxt  = rd_idx_q + CW'(1);
	assign wr_en       = in_xfer && (state_q == S_PAYLOAD) &&
		({{(8-CW){1'b0}}, count_q} < MAX_B);
	assign rd_en       = (state_q == S_RD);

	slxfr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_payload_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (s_axis_tdata),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= EXP_LEN_RESET;
		end else if (cfg_we) begin
			exp_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_HUNT;
			check_q   <= '0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_HUNT: begin
					if (in_xfer && cmp_eq) begin
						state_q <= S_SECOND;
					end
				end
				S_SECOND: begin
					if (in_xfer) begin
						if (cmp_eq) begin
							state_q <= S_LENGTH;
						end else begin
							m_valid_q <= 1'b1;
							state_q   <= S_HUNT;
						end
					end
				end
				S_LENGTH: begin
					if (in_xfer) begin
						if (cmp_eq && !len_bad_cfg) begin
							check_q <= s_axis_tdata;
							count_q <= '0;
							state_q <= S_PAYLOAD;
						end else begin
							m_valid_q <= 1'b1;
							state_q   <= S_HUNT;
						end
					end
				end
				S_PAYLOAD: begin
					if (in_xfer) begin
						check_q <= check_q ^ s_axis_tdata;
						if (wr_en) begin
							count_q <= count_nxt;
						end
						if (({{(8-CW){1'b0}}, count_nxt} >= {1'b0, exp_len_q}) ||
							({{(8-CW){1'b0}}, count_nxt} >= MAX_B)) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (in_xfer) begin
						if (cmp_eq) begin
							rd_idx_q <= '0;
							state_q  <= S_RD;
						end else begin
							m_valid_q <= 1'b1;
							state_q   <= S_HUNT;
						end
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						rd_idx_q  <= rd_idx_nxt;
						state_q   <= (rd_idx_nxt == count_q) ? S_HUNT : S_RD;
					end
				end
				default: begin
					state_q <= S_HUNT;
				end
			endcase
		end
	end

	// output register: error results or payload bytes
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_data_q <= 8'h00;
			m_last_q <= 1'b1;
			case (state_q)
				S_SECOND: m_user_q <= ST_BAD_START;
				S_LENGTH: m_user_q <= ST_BAD_LENGTH;
				default:  m_user_q <= ST_BAD_CHECK;
			endcase
		end else if ((state_q == S_LOAD) && out_free) begin
			m_data_q <= ram_q;
			m_user_q <= ST_DATA;
			m_last_q <= (rd_idx_nxt == count_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

@@ sv/slxfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfr_props
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slxfr_props
	import slxfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// master transfer held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("output transfer changed while stalled");

	a_no_rx_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken with result pending");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_DATA) |->
		m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("error result malformed");

	a_err_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) && (m_axis_tuser != ST_DATA) |->
		$past(s_axis_tvalid && s_axis_tready))
		else $error("error result without an input transfer");

endmodule

bind sync_length_xor_frame_receiver slxfr_props u_slxfr_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
